>>> rtl/hntv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hntv_pkg;

   // fixed field widths
   localparam int PATTERN_W = 6;
   localparam int WEIGHT_W  = 16;
   localparam int INDEX_W   = 5;
   localparam int SUM_W     = 21;
   localparam int THRESH_W  = 16;
   localparam int DIST_W    = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int POP_W     = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERABLE_DISTANCE = 2'd1;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1;
   localparam logic [DIST_W-1:0]   DIST_RESET   = 6'd0;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic [WEIGHT_W-1:0]  weight;
      logic                 final_entry;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_W-1:0] entry_index;
      logic               verdict;
      logic [SUM_W-1:0]   neighbour_sum;
      logic               dropped_flag;
      logic               last_result;
   } rsp_payload_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic [WEIGHT_W-1:0]  weight;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE_RD,
      ST_BASE_LD,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // number of set bits in a pattern
   function automatic logic [POP_W-1:0] popcount(input logic [PATTERN_W-1:0] v);
      logic [POP_W-1:0] n;
      n = '0;
      for (int k = 0; k < PATTERN_W; k++) begin
         n = n + POP_W'(v[k]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

>>> rtl/hamming_neighbour_threshold_vote.sv
`timescale 1ns / 1ps
`default_nettype none

// Collects a set of entries (pattern, Q8.8 weight) into an on-chip store; the beat
// with final_entry set closes the set. For each stored entry, in load order, the
// block sums its own weight plus the weights of all entries whose pattern differs
// but lies within tolerable_distance bits, then emits one result beat: sum at or
// below detect_threshold (whole number, i.e. threshold * 256 in Q8.8) is attack,
// above it tolerate. Entries beyond MAX_ENTRIES are dropped and flagged on every
// result of that set. The store has a single read port, so each stored entry is
// evaluated in turn: one base read, a pipelined read of every stored entry, drain,
// result; a stall on the result side holds the evaluation. Input beats are taken
// one per cycle while collecting; no input is accepted during evaluation.
// Configuration is written while idle: a rule for the user, not enforced by the block.
module hamming_neighbour_threshold_vote
   import hntv_pkg::*;
#(
   parameter int MAX_ENTRIES  = 32,
   parameter int PATTERN_BITS = 6
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  req_payload_type        req_data,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output rsp_payload_type              rsp_data,
   input  wire                          csr_we,
   input  wire  [CSR_IDX_W-1:0]         csr_index,
   input  wire  [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [PATTERN_W-1:0] PAT_MASK = (PATTERN_BITS >= PATTERN_W) ?
      {PATTERN_W{1'b1}} : PATTERN_W'((1 << PATTERN_BITS) - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);
   localparam logic [SUM_W:0]   SUM_MAX  = {1'b0, {SUM_W{1'b1}}};

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff;
   logic                 overflow_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     scan_ff;
   logic [PATTERN_W-1:0] base_pat_ff;
   logic [SUM_W-1:0]     sum_ff;
   entry_type            rd_data_ff;
   rsp_payload_type      rsp_ff;
   logic                 rsp_valid_ff;
   logic [THRESH_W-1:0]  thresh_ff;
   logic [DIST_W-1:0]    tol_ff;

   entry_type            store_mem [MAX_ENTRIES];

   logic                 req_accept;
   logic                 full;
   logic                 scan_last;
   logic                 idx_last;
   logic                 rsp_free;
   logic [IDX_W-1:0]     rd_addr;
   logic                 cap_base;
   logic                 acc_en;
   logic                 emit_fire;
   logic                 is_neighbour;
   logic [SUM_W:0]       sum_add;
   logic [SUM_W-1:0]     sum_next;
   logic [SUM_W+2:0]     limit;

   // status terms
   assign req_accept = req_valid && req_ready;
   assign full       = (count_ff == CNT_FULL);
   assign scan_last  = (CNT_W'(scan_ff) == (count_ff - CNT_W'(1)));
   assign idx_last   = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_data.final_entry) state_in = ST_BASE_RD;
         end
         ST_BASE_RD: state_in = ST_BASE_LD;
         ST_BASE_LD, ST_SCAN: begin
            state_in = scan_last ? ST_DRAIN : ST_SCAN;
         end
         ST_DRAIN: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) state_in = idx_last ? ST_IDLE : ST_BASE_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      rd_addr   = scan_ff;
      cap_base  = 1'b0;
      acc_en    = 1'b0;
      emit_fire = 1'b0;
      case (state_ff)
         ST_IDLE:    req_ready = 1'b1;
         ST_BASE_RD: rd_addr = idx_ff;
         ST_BASE_LD: cap_base = 1'b1;
         ST_SCAN:    acc_en = 1'b1;
         ST_DRAIN:   acc_en = 1'b1;
         ST_EMIT:    emit_fire = rsp_free;
         default:    req_ready = 1'b0;
      endcase
   end

   // neighbour test and saturating accumulate
   assign is_neighbour = (rd_data_ff.pattern != base_pat_ff) &&
      ({{(DIST_W-POP_W){1'b0}}, popcount(rd_data_ff.pattern ^ base_pat_ff)} <= tol_ff);
   assign sum_add  = {1'b0, sum_ff} + (SUM_W+1)'(rd_data_ff.weight);
   assign sum_next = (sum_add > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_add[SUM_W-1:0];
   assign limit    = {thresh_ff, 8'd0};

   // entry store
   always_ff @(posedge clock) begin
      if (req_accept && !full) begin
         store_mem[count_ff[IDX_W-1:0]] <= '{pattern: req_data.pattern & PAT_MASK,
                                             weight: req_data.weight};
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         idx_ff       <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= THRESH_RESET;
         tol_ff       <= DIST_RESET;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            idx_ff <= '0;
            if (full) overflow_ff <= 1'b1;
            else      count_ff    <= count_ff + CNT_W'(1);
         end
         if (state_ff == ST_BASE_RD) scan_ff <= '0;
         else if (cap_base || acc_en) scan_ff <= scan_ff + IDX_W'(1);
         if (emit_fire) begin
            idx_ff <= idx_ff + IDX_W'(1);
            if (idx_last) begin
               count_ff    <= '0;
               overflow_ff <= 1'b0;
            end
         end
         if (emit_fire)      rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         // configuration writes
         if (csr_we) begin
            case (csr_index)
               CSR_DETECT_THRESHOLD:   thresh_ff <= csr_wdata[THRESH_W-1:0];
               CSR_TOLERABLE_DISTANCE: tol_ff    <= csr_wdata[DIST_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cap_base) begin
         base_pat_ff <= rd_data_ff.pattern;
         sum_ff      <= SUM_W'(rd_data_ff.weight);
      end else if (acc_en && is_neighbour) begin
         sum_ff <= sum_next;
      end
      if (emit_fire) begin
         rsp_ff.entry_index   <= INDEX_W'(idx_ff);
         rsp_ff.verdict       <= ((SUM_W+3)'(sum_ff) > limit);
         rsp_ff.neighbour_sum <= sum_ff;
         rsp_ff.dropped_flag  <= overflow_ff;
         rsp_ff.last_result   <= idx_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count beyond capacity");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && idx_last) |=> (count_ff == '0 && !overflow_ff))
      else $error("set not cleared after last result");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result beat raised outside result state");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && !idx_last) |=> (state_ff == ST_BASE_RD))
      else $error("evaluation stopped before last entry");

endmodule

`default_nettype wire

>>> dv/hamming_neighbour_threshold_vote_tb.sv
`timescale 1ns / 1ps

module hamming_neighbour_threshold_vote_tb
   import hntv_pkg::*;
();

   localparam int MAX_HELD    = 32;
   localparam int SUM_CAP     = 32'h1F_FFFF;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_BEATS = 100;
   localparam int CALM_AFTER  = 80;
   localparam int MAX_REPORTS = 10;

   // indexes past the last register, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // tracks the stored set and the verdicts it must produce
   class vote_scoreboard;
      logic [PATTERN_W-1:0] held_pattern [MAX_HELD];
      logic [WEIGHT_W-1:0]  held_weight [MAX_HELD];
      int unsigned          held_count;
      bit                   overflowed;
      logic [THRESH_W-1:0]  threshold;
      logic [DIST_W-1:0]    distance;
      rsp_payload_type      pending_verdicts[$];
      int unsigned          mismatches;
      int unsigned          beats_taken;
      int unsigned          sets_closed;
      int unsigned          attacks;
      int unsigned          tolerates;
      int unsigned          dropped_results;

      function new();
         threshold = THRESH_RESET;
         distance  = DIST_RESET;
         held_count = 0;
         overflowed = 1'b0;
         mismatches = 0;
         beats_taken = 0;
         sets_closed = 0;
         attacks = 0;
         tolerates = 0;
         dropped_results = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_DETECT_THRESHOLD) begin
            threshold = val[THRESH_W-1:0];
         end else if (idx == CSR_TOLERABLE_DISTANCE) begin
            distance = val[DIST_W-1:0];
         end
      endfunction

      // store one entry; a final beat turns the whole set into verdicts
      function void take_entry(input req_payload_type beat);
         rsp_payload_type want;
         logic [PATTERN_W-1:0] diff;
         int unsigned sum;
         int unsigned limit;
         int unsigned apart;
         beats_taken++;
         if (held_count < MAX_HELD) begin
            held_pattern[held_count] = beat.pattern;
            held_weight[held_count]  = beat.weight;
            held_count++;
         end else begin
            overflowed = 1'b1;
         end
         if (!beat.final_entry) return;
         sets_closed++;
         limit = int'(threshold) << 8;
         for (int i = 0; i < held_count; i++) begin
            sum = held_weight[i];
            for (int j = 0; j < held_count; j++) begin
               diff = held_pattern[i] ^ held_pattern[j];
               apart = 0;
               for (int k = 0; k < PATTERN_W; k++) apart += diff[k];
               if (diff != '0 && apart <= distance) begin
                  sum += held_weight[j];
                  if (sum > SUM_CAP) sum = SUM_CAP;
               end
            end
            want.entry_index   = INDEX_W'(i);
            want.verdict       = (sum > limit);
            want.neighbour_sum = SUM_W'(sum);
            want.dropped_flag  = overflowed;
            want.last_result   = (i + 1 == held_count);
            pending_verdicts.push_back(want);
         end
         held_count = 0;
         overflowed = 1'b0;
      endfunction

      function void check_verdict(input rsp_payload_type got);
         rsp_payload_type want;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result beat with none expected: idx=%0d verdict=%0d sum=%0d",
                        $realtime, got.entry_index, got.verdict, got.neighbour_sum);
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.verdict) tolerates++;
         else attacks++;
         if (got.dropped_flag) dropped_results++;
         if (got.entry_index !== want.entry_index || got.verdict !== want.verdict ||
             got.neighbour_sum !== want.neighbour_sum ||
             got.dropped_flag !== want.dropped_flag ||
             got.last_result !== want.last_result) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: mismatch expected idx=%0d verdict=%0d sum=%0d drop=%0d last=%0d",
                        $realtime, want.entry_index, want.verdict, want.neighbour_sum,
                        want.dropped_flag, want.last_result);
               $display("%0t:          actual   idx=%0d verdict=%0d sum=%0d drop=%0d last=%0d",
                        $realtime, got.entry_index, got.verdict, got.neighbour_sum,
                        got.dropped_flag, got.last_result);
            end
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_payload_type         req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_payload_type         rsp_data;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   bit                      calm = 1'b0;

   vote_scoreboard sb = new();

   hamming_neighbour_threshold_vote i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 50 MHz clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result beats are checked at the edge that takes them
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_verdict(rsp_data);
   end

   // receiver back-pressure in random bursts
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // one entry beat, with an optional gap ahead of it
   task automatic send_entry(input logic [PATTERN_W-1:0] pat,
                             input logic [WEIGHT_W-1:0] wgt, input logic fin);
      req_payload_type beat;
      beat.pattern     = pat;
      beat.weight      = wgt;
      beat.final_entry = fin;
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_entry(beat);
   endtask

   // hold off the sender until every verdict is back and the block has settled
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic retune(input logic [CSR_DATA_W-1:0] thr,
                         input logic [CSR_DATA_W-1:0] dist_word);
      drain_results();
      write_csr(CSR_DETECT_THRESHOLD, thr);
      write_csr(CSR_TOLERABLE_DISTANCE, dist_word);
   endtask

   // stimulus
   initial begin
      int unsigned          sent;
      int unsigned          set_len;
      bit                   overflow_done;
      logic [PATTERN_W-1:0] base;
      logic [PATTERN_W-1:0] pat;
      logic [PATTERN_W-1:0] prev;
      logic [WEIGHT_W-1:0]  wgt;
      logic [CSR_DATA_W-1:0] thr;
      logic [CSR_DATA_W-1:0] dist_word;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: distance 0 means no neighbours, threshold sits at 256
      send_entry(6'h00, 16'h0000, 1'b0);
      send_entry(6'h00, 16'h0100, 1'b0);
      send_entry(6'h3F, 16'h0101, 1'b1);
      // a set of one entry
      send_entry(6'h2A, 16'hFFFF, 1'b1);

      // zero threshold, one-bit neighbourhood, writes past the last register
      drain_results();
      write_csr(CSR_SPARE_A, 16'hFFFF);
      write_csr(CSR_SPARE_B, 16'hFFFF);
      write_csr(CSR_DETECT_THRESHOLD, 16'h0000);
      write_csr(CSR_TOLERABLE_DISTANCE, 16'h0001);
      send_entry(6'h00, 16'hFFFF, 1'b0);
      send_entry(6'h01, 16'h0001, 1'b0);
      send_entry(6'h03, 16'h0002, 1'b0);
      send_entry(6'h01, 16'h0000, 1'b0);
      send_entry(6'h3F, 16'hFFFF, 1'b1);

      // top threshold, widest distance written with high data bits set
      retune(16'hFFFF, 16'hFFFF);
      send_entry(6'h00, 16'hFFFF, 1'b0);
      send_entry(6'h3F, 16'hFFFF, 1'b0);
      send_entry(6'h15, 16'hFFFF, 1'b0);
      send_entry(6'h2A, 16'hFFFF, 1'b0);
      send_entry(6'h3F, 16'h8000, 1'b0);
      send_entry(6'h01, 16'h7FFF, 1'b1);

      // exactly six bits apart still counts at distance six
      retune(16'd600, 16'd6);
      send_entry(6'h00, 16'h9000, 1'b0);
      send_entry(6'h3F, 16'hC000, 1'b0);
      send_entry(6'h00, 16'h0001, 1'b0);
      send_entry(6'h1E, 16'h4000, 1'b1);

      // random sets around a base pattern, one of them past capacity
      sent = 0;
      overflow_done = 1'b0;
      prev = '0;
      while (sent < RANDOM_BEATS) begin
         if (sent >= CALM_AFTER) calm = 1'b1;
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 7))
               0: thr = 16'h0000;
               1: thr = 16'hFFFF;
               default: thr = CSR_DATA_W'($urandom_range(0, 600));
            endcase
            if ($urandom_range(0, 4) == 0) begin
               dist_word = CSR_DATA_W'($urandom);
            end else begin
               dist_word = CSR_DATA_W'($urandom_range(0, 6));
            end
            retune(thr, dist_word);
         end
         if (!overflow_done && sent >= 30) begin
            set_len = MAX_HELD + $urandom_range(1, 3);
            overflow_done = 1'b1;
         end else if ($urandom_range(0, 7) == 0) begin
            set_len = $urandom_range(9, MAX_HELD);
         end else begin
            set_len = $urandom_range(1, 6);
         end
         base = PATTERN_W'($urandom);
         for (int n = 0; n < set_len; n++) begin
            case ($urandom_range(0, 4))
               0: pat = PATTERN_W'($urandom);
               1: pat = prev;
               default: begin
                  pat = base;
                  repeat ($urandom_range(0, 3)) pat[$urandom_range(0, PATTERN_W - 1)] ^= 1'b1;
               end
            endcase
            case ($urandom_range(0, 9))
               0: wgt = '0;
               1: wgt = '1;
               default: wgt = WEIGHT_W'($urandom);
            endcase
            send_entry(pat, wgt, n == set_len - 1);
            prev = pat;
         end
         sent += set_len;
      end

      drain_results();
      $display("run covered %0d entry beats in %0d sets, %0d verdicts (%0d attack, %0d tolerate)",
               sb.beats_taken, sb.sets_closed, sb.attacks + sb.tolerates, sb.attacks,
               sb.tolerates);
      $display("%0d verdicts carried the dropped mark, %0d mismatches",
               sb.dropped_results, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #50_000_000;
      $display("timeout with %0d verdicts outstanding", sb.pending_verdicts.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> sim.f
rtl/hntv_pkg.sv
rtl/hamming_neighbour_threshold_vote.sv
dv/hamming_neighbour_threshold_vote_tb.sv
